// File: rtl/core/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; NO_ASSERTIONS compiles them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// expression must never be true outside reset
`define ASSERT_NEVER(name, clk, rstn, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_HOLDS(name, clk, rstn, prop, msg)
`define ASSERT_NEVER(name, clk, rstn, expr, msg)
`endif
`endif

// File: rtl/core/nsc_pkg.sv
// types, constants and helpers for the nmea sentence checker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nsc_pkg;

  localparam int DEFAULT_MAX_FIELDS = 255;
  localparam int HELD_DEPTH = 7;
  // held terminators that can still reach the identifier
  localparam int HELD_KEEP = 6;
  localparam int HELD_CNT_W = $clog2(HELD_DEPTH + 1);
  localparam int HELD_IDX_W = $clog2(HELD_KEEP);
  localparam int ID_LEN = 5;
  localparam int BODY_W = 3;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef enum logic [2:0] {
    ST_OK,
    ST_EMPTY,
    ST_NO_START,
    ST_NO_STAR,
    ST_SHORT_CSUM,
    ST_BAD_HEX,
    ST_SHORT_ID,
    ST_BAD_ID
  } status_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       has_byte;
    logic       end_of_sentence;
  } in_t;

  typedef struct packed {
    logic [2:0]  status_code;
    logic        checksum_ok;
    logic        sentence_valid;
    logic [7:0]  field_count;
    logic [39:0] talker_identifier;
    logic [7:0]  received_checksum;
    logic [7:0]  computed_checksum;
  } out_t;

  // returns {digit valid, nibble value}
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    logic [4:0] r;
    r = 5'h00;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/nmea_sentence_checker.sv
// nmea 0183 sentence checker: one character beat per cycle (an end beat stalls while
// the result register is full and not taken), one result per sentence
// depends on nsc_pkg and assert_macros.svh
// path: a sentence's end beat goes through the input register, then one pass of flag/xor logic into the result register
// throughput: one beat per cycle save that stall; held cr/lf runs replay in that pass
// reset: asynchronous, clears all sentence state; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module nmea_sentence_checker #(
  parameter int MAX_FIELDS = nsc_pkg::DEFAULT_MAX_FIELDS
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire nsc_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output nsc_pkg::out_t     out_data_o
);

  localparam int CW = $clog2(MAX_FIELDS + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_FIELDS);
  localparam int HW = nsc_pkg::HELD_CNT_W;
  localparam int BW = nsc_pkg::BODY_W;

  // input register
  logic         in_valid_q;
  nsc_pkg::in_t in_q;
  logic         adv;

  // sentence state
  logic                           any_q, any_d;
  logic                           dollar_q, dollar_d;
  logic                           star_q, star_d;
  logic [1:0]                     bas_q, bas_d;
  logic [BW-1:0]                  blen_q, blen_d;
  logic                           sixth_q, sixth_d;
  logic [7:0]                     xor_q, xor_d;
  logic [7:0]                     hexd_q, hexd_d;
  logic                           hexbad_q, hexbad_d;
  logic [CW-1:0]                  comma_q, comma_d;
  logic [39:0]                    ident_q, ident_d;
  logic [nsc_pkg::HELD_KEEP-1:0]  held_q, held_d;   // 1 = cr, 0 = lf
  logic [HW-1:0]                  hcnt_q, hcnt_d;
  logic [7:0]                     hxor_q, hxor_d;

  // result register
  logic          out_valid_q;
  nsc_pkg::out_t out_q, res;

  logic [7:0]    b;
  logic          is_term;
  logic          off;
  logic [HW-1:0] m;
  logic [3:0]    bas_sum;
  logic [3:0]    blen_sum;
  logic [4:0]    nib;
  logic [HW-1:0] hidx;
  nsc_pkg::status_e st;
  logic [CW-1:0] fc_w;
  logic          ck;

  assign adv = in_valid_q && (!in_q.end_of_sentence || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  assign b = in_q.char_byte;
  assign is_term = (b == nsc_pkg::CH_CR) || (b == nsc_pkg::CH_LF);

  // state after this beat's byte, before the end-of-sentence clear
  always_comb begin
    any_d = any_q;
    dollar_d = dollar_q;
    star_d = star_q;
    bas_d = bas_q;
    blen_d = blen_q;
    sixth_d = sixth_q;
    xor_d = xor_q;
    hexd_d = hexd_q;
    hexbad_d = hexbad_q;
    comma_d = comma_q;
    ident_d = ident_q;
    held_d = held_q;
    hcnt_d = hcnt_q;
    hxor_d = hxor_q;
    off = !any_q;
    m = hcnt_q - HW'(off);
    bas_sum = 4'(bas_q) + 4'(m);
    blen_sum = 4'(blen_q) + 4'(m);
    nib = 5'h00;
    hidx = '0;
    if (in_q.has_byte) begin
      if (is_term) begin
        if (hcnt_q < HW'(nsc_pkg::HELD_DEPTH)) begin
          if (hcnt_q < HW'(nsc_pkg::HELD_KEEP)) begin
            held_d[hcnt_q[nsc_pkg::HELD_IDX_W-1:0]] = (b == nsc_pkg::CH_CR);
          end
          hcnt_d = hcnt_q + 1'b1;
        end
        hxor_d = hxor_q ^ b;
      end else begin
        // replay the held run: all cr/lf, so its effect has a closed form
        if (hcnt_q != '0) begin
          if (!any_q) begin
            any_d = 1'b1;
            dollar_d = 1'b0;
          end
          if (star_q) begin
            if (m != '0 && bas_q < 2'd2) hexbad_d = 1'b1;
            bas_d = (bas_sum > 4'd2) ? 2'd2 : bas_sum[1:0];
          end else begin
            for (int j = 0; j < nsc_pkg::ID_LEN; j++) begin
              hidx = HW'(off) + HW'(j);
              if (4'(j) < 4'(m) && 4'(blen_q) + 4'(j) < 4'(nsc_pkg::ID_LEN)) begin
                ident_d = {ident_d[31:0],
                           held_q[hidx[nsc_pkg::HELD_IDX_W-1:0]] ? nsc_pkg::CH_CR
                                                                 : nsc_pkg::CH_LF};
              end
            end
            if (4'(blen_q) <= 4'(nsc_pkg::ID_LEN) && blen_sum > 4'(nsc_pkg::ID_LEN)) begin
              sixth_d = 1'b0;
            end
            blen_d = (blen_sum > 4'(nsc_pkg::ID_LEN + 1)) ? BW'(nsc_pkg::ID_LEN + 1)
                                                         : blen_sum[BW-1:0];
            if (dollar_d) xor_d = xor_d ^ hxor_q;
          end
          hcnt_d = '0;
          hxor_d = 8'h00;
        end
        // the beat's own byte
        if (!any_d) begin
          any_d = 1'b1;
          dollar_d = (b == nsc_pkg::CH_DOLLAR);
        end else if (star_d) begin
          if (bas_d < 2'd2) begin
            nib = nsc_pkg::hex_nibble(b);
            if (!nib[4]) begin
              hexbad_d = 1'b1;
            end else if (bas_d == 2'd0) begin
              hexd_d = {nib[3:0], 4'h0};
            end else begin
              hexd_d = hexd_d | {4'h0, nib[3:0]};
            end
            bas_d = bas_d + 2'd1;
          end
        end else if (b == nsc_pkg::CH_STAR) begin
          star_d = 1'b1;
        end else begin
          xor_d = xor_d ^ b;
          if (blen_d < BW'(nsc_pkg::ID_LEN)) begin
            ident_d = {ident_d[31:0], b};
          end else if (blen_d == BW'(nsc_pkg::ID_LEN)) begin
            sixth_d = (b == nsc_pkg::CH_COMMA);
          end else if (b == nsc_pkg::CH_COMMA && comma_d < MaxCount) begin
            comma_d = comma_d + 1'b1;
          end
          if (blen_d < BW'(nsc_pkg::ID_LEN + 1)) blen_d = blen_d + 1'b1;
        end
      end
    end
  end

  // result of a sentence from the updated state
  always_comb begin
    priority if (!any_d) st = nsc_pkg::ST_EMPTY;
    else if (!dollar_d) st = nsc_pkg::ST_NO_START;
    else if (!star_d) st = nsc_pkg::ST_NO_STAR;
    else if (bas_d < 2'd2) st = nsc_pkg::ST_SHORT_CSUM;
    else if (hexbad_d) st = nsc_pkg::ST_BAD_HEX;
    else if (blen_d < BW'(nsc_pkg::ID_LEN)) st = nsc_pkg::ST_SHORT_ID;
    else if (blen_d > BW'(nsc_pkg::ID_LEN) && !sixth_d) st = nsc_pkg::ST_BAD_ID;
    else st = nsc_pkg::ST_OK;

    fc_w = (comma_d == MaxCount) ? MaxCount : comma_d + 1'b1;
    ck = 1'b0;
    res = '0;
    res.status_code = st;
    if (st == nsc_pkg::ST_OK || st == nsc_pkg::ST_SHORT_CSUM || st == nsc_pkg::ST_BAD_HEX ||
        st == nsc_pkg::ST_SHORT_ID || st == nsc_pkg::ST_BAD_ID) begin
      res.computed_checksum = xor_d;
    end
    if (st == nsc_pkg::ST_OK || st == nsc_pkg::ST_SHORT_ID || st == nsc_pkg::ST_BAD_ID) begin
      res.received_checksum = hexd_d;
      ck = (hexd_d == xor_d);
    end
    if (st == nsc_pkg::ST_OK || st == nsc_pkg::ST_BAD_ID) res.talker_identifier = ident_d;
    if (st == nsc_pkg::ST_OK && blen_d > BW'(nsc_pkg::ID_LEN)) res.field_count = 8'(fc_w);
    res.checksum_ok = ck;
    res.sentence_valid = (st == nsc_pkg::ST_OK) && ck;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      any_q <= 1'b0;
      dollar_q <= 1'b0;
      star_q <= 1'b0;
      bas_q <= '0;
      blen_q <= '0;
      sixth_q <= 1'b0;
      xor_q <= '0;
      hexd_q <= '0;
      hexbad_q <= 1'b0;
      comma_q <= '0;
      ident_q <= '0;
      held_q <= '0;
      hcnt_q <= '0;
      hxor_q <= '0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (adv && in_q.end_of_sentence) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (adv) begin
        if (in_q.end_of_sentence) begin
          any_q <= 1'b0;
          dollar_q <= 1'b0;
          star_q <= 1'b0;
          bas_q <= '0;
          blen_q <= '0;
          sixth_q <= 1'b0;
          xor_q <= '0;
          hexd_q <= '0;
          hexbad_q <= 1'b0;
          comma_q <= '0;
          ident_q <= '0;
          held_q <= '0;
          hcnt_q <= '0;
          hxor_q <= '0;
        end else begin
          any_q <= any_d;
          dollar_q <= dollar_d;
          star_q <= star_d;
          bas_q <= bas_d;
          blen_q <= blen_d;
          sixth_q <= sixth_d;
          xor_q <= xor_d;
          hexd_q <= hexd_d;
          hexbad_q <= hexbad_d;
          comma_q <= comma_d;
          ident_q <= ident_d;
          held_q <= held_d;
          hcnt_q <= hcnt_d;
          hxor_q <= hxor_d;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    if (adv && in_q.end_of_sentence) out_q <= res;
  end

  `ASSERT_HOLDS(a_result_from_end_beat, clk_i, rst_ni, $rose(out_valid_q) |-> $past(adv && in_q.end_of_sentence), "result appeared without an end beat")
  `ASSERT_HOLDS(a_valid_means_ok, clk_i, rst_ni, out_valid_q |-> (!out_q.sentence_valid || (out_q.status_code == nsc_pkg::ST_OK && out_q.checksum_ok)), "sentence_valid without ok status and checksum")
  `ASSERT_HOLDS(a_cleared_after_end, clk_i, rst_ni, (adv && in_q.end_of_sentence) |=> (!any_q && hcnt_q == '0 && comma_q == '0), "state not cleared after end beat")
  `ASSERT_NEVER(a_stall_needs_item, clk_i, rst_ni, !in_ready_o && !in_valid_q, "input stalled with empty input register")

endmodule

`default_nettype wire
